>>> src/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared constants, sector codes and stage payload types of the HSV to RGB
// converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

   localparam int FRAC_BITS = 12;
   localparam int DATA_W    = FRAC_BITS + 1;
   localparam int SECTOR_W  = 3;
   localparam int HUE6_W    = DATA_W + SECTOR_W - 1;
   localparam int PROD_W    = 2 * DATA_W;

   localparam logic [DATA_W-1:0] ONE_VAL = DATA_W'(1) << FRAC_BITS;
   localparam logic [HUE6_W-1:0] SECTORS = HUE6_W'(6);

   typedef enum logic [SECTOR_W-1:0] {
      SECTOR_RY = 3'd0,
      SECTOR_YG = 3'd1,
      SECTOR_GC = 3'd2,
      SECTOR_CB = 3'd3,
      SECTOR_BM = 3'd4,
      SECTOR_MR = 3'd5
   } sector_type;

   typedef struct packed {
      logic [DATA_W-1:0]    sat;
      logic [DATA_W-1:0]    val;
      logic [FRAC_BITS-1:0] frac;
      sector_type           sector;
      logic                 gray;
   } hue_stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] sat_inv;
      logic [DATA_W-1:0] sat_frac;
      logic [DATA_W-1:0] sat_frac_inv;
      logic [DATA_W-1:0] val;
      sector_type        sector;
      logic              gray;
   } sat_stage_type;

   typedef struct packed {
      logic [DATA_W-1:0] p;
      logic [DATA_W-1:0] q;
      logic [DATA_W-1:0] t;
      logic [DATA_W-1:0] val;
      sector_type        sector;
      logic              gray;
   } chan_stage_type;

endpackage

>>> src/hsv2rgb_sector.sv
// ----------------------------------------------------------------------------
// hsv2rgb_sector
// First stage: saturate saturation and value to 1.0, set a hue of 1.0 or more to zero,
// and split hue * 6 into sector and fraction.
// ----------------------------------------------------------------------------
module hsv2rgb_sector
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_hue,
   input  logic [DATA_W-1:0] in_sat,
   input  logic [DATA_W-1:0] in_val,
   output logic              out_valid,
   input  logic              out_ready,
   output hue_stage_type     out_data
);

   logic              valid_ff;
   hue_stage_type     data_ff;
   hue_stage_type     data_in;
   logic [DATA_W-1:0] hue_c;
   logic [DATA_W-1:0] sat_c;
   logic [DATA_W-1:0] val_c;
   logic [HUE6_W-1:0] hue6;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      hue_c = (in_hue >= ONE_VAL) ? '0 : in_hue;
      sat_c = (in_sat > ONE_VAL) ? ONE_VAL : in_sat;
      val_c = (in_val > ONE_VAL) ? ONE_VAL : in_val;
      hue6  = HUE6_W'(hue_c) * SECTORS;
      data_in.sat    = sat_c;
      data_in.val    = val_c;
      data_in.frac   = hue6[FRAC_BITS-1:0];
      data_in.sector = sector_type'(hue6[FRAC_BITS +: SECTOR_W]);
      data_in.gray   = (sat_c == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// Second and third stages: form s*f and s*(1-f), then scale value by
// (1-s), (1-sf) and (1-s(1-f)) to get p, q and t.
// ----------------------------------------------------------------------------
module hsv2rgb_scale
   import hsv2rgb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  hue_stage_type  in_data,
   output logic           out_valid,
   input  logic           out_ready,
   output chan_stage_type out_data
);

   logic              s1_valid_ff;
   sat_stage_type     s1_data_ff;
   sat_stage_type     s1_data_in;
   logic              s1_ready;
   logic              s2_valid_ff;
   chan_stage_type    s2_data_ff;
   chan_stage_type    s2_data_in;
   logic [DATA_W-1:0] frac_inv;
   logic [PROD_W-1:0] prod_sf;
   logic [PROD_W-1:0] prod_sfc;
   logic [PROD_W-1:0] prod_p;
   logic [PROD_W-1:0] prod_q;
   logic [PROD_W-1:0] prod_t;

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;
   assign s1_ready  = !s2_valid_ff || out_ready;
   assign in_ready  = !s1_valid_ff || s1_ready;

   always_comb begin
      frac_inv = ONE_VAL - DATA_W'(in_data.frac);
      prod_sf  = PROD_W'(in_data.sat) * PROD_W'(in_data.frac);
      prod_sfc = PROD_W'(in_data.sat) * PROD_W'(frac_inv);
      s1_data_in.sat_inv      = ONE_VAL - in_data.sat;
      s1_data_in.sat_frac     = prod_sf[FRAC_BITS +: DATA_W];
      s1_data_in.sat_frac_inv = prod_sfc[FRAC_BITS +: DATA_W];
      s1_data_in.val          = in_data.val;
      s1_data_in.sector       = in_data.sector;
      s1_data_in.gray         = in_data.gray;
   end

   always_comb begin
      prod_p = PROD_W'(s1_data_ff.val) * PROD_W'(s1_data_ff.sat_inv);
      prod_q = PROD_W'(s1_data_ff.val) * PROD_W'(ONE_VAL - s1_data_ff.sat_frac);
      prod_t = PROD_W'(s1_data_ff.val) * PROD_W'(ONE_VAL - s1_data_ff.sat_frac_inv);
      s2_data_in.p      = prod_p[FRAC_BITS +: DATA_W];
      s2_data_in.q      = prod_q[FRAC_BITS +: DATA_W];
      s2_data_in.t      = prod_t[FRAC_BITS +: DATA_W];
      s2_data_in.val    = s1_data_ff.val;
      s2_data_in.sector = s1_data_ff.sector;
      s2_data_in.gray   = s1_data_ff.gray;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s1_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_data_ff <= s1_data_in;
      end
      if (s1_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

endmodule

>>> src/hsv2rgb_route.sv
// ----------------------------------------------------------------------------
// hsv2rgb_route
// Output stage: route v, p, q and t to red, green and blue by sector, or v to all three for gray.
// ----------------------------------------------------------------------------
module hsv2rgb_route
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  chan_stage_type    in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_red,
   output logic [DATA_W-1:0] out_green,
   output logic [DATA_W-1:0] out_blue
);

   logic              valid_ff;
   logic [DATA_W-1:0] red_ff;
   logic [DATA_W-1:0] green_ff;
   logic [DATA_W-1:0] blue_ff;
   logic [DATA_W-1:0] red_in;
   logic [DATA_W-1:0] green_in;
   logic [DATA_W-1:0] blue_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_data.gray) begin
         red_in   = in_data.val;
         green_in = in_data.val;
         blue_in  = in_data.val;
      end else begin
         unique case (in_data.sector)
            SECTOR_RY: begin
               red_in = in_data.val; green_in = in_data.t;   blue_in = in_data.p;
            end
            SECTOR_YG: begin
               red_in = in_data.q;   green_in = in_data.val; blue_in = in_data.p;
            end
            SECTOR_GC: begin
               red_in = in_data.p;   green_in = in_data.val; blue_in = in_data.t;
            end
            SECTOR_CB: begin
               red_in = in_data.p;   green_in = in_data.q;   blue_in = in_data.val;
            end
            SECTOR_BM: begin
               red_in = in_data.t;   green_in = in_data.p;   blue_in = in_data.val;
            end
            default: begin
               red_in = in_data.val; green_in = in_data.p;   blue_in = in_data.q;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_red   = red_ff;
   assign out_green = green_ff;
   assign out_blue  = blue_ff;

endmodule

>>> src/hsv_to_rgb_converter_unit.sv
// Each request passes the register stages named below in order before its result shows on rsp_*.
// Throughput: one item per cycle while rsp_ready stays high; four register stages (sector split,
// saturation products, value products, channel routing) each advance on their own.
// Each stage takes a new item while a later one holds a result.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Pipelined HSV to RGB pixel converter on Q1.12 fractions.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
   import hsv2rgb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [DATA_W-1:0] req_hue,
   input  logic [DATA_W-1:0] req_saturation,
   input  logic [DATA_W-1:0] req_brightness,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_red,
   output logic [DATA_W-1:0] rsp_green,
   output logic [DATA_W-1:0] rsp_blue
);

   logic           hue_valid;
   logic           hue_ready;
   hue_stage_type  hue_data;
   logic           chan_valid;
   logic           chan_ready;
   chan_stage_type chan_data;

   hsv2rgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_hue    (req_hue),
      .in_sat    (req_saturation),
      .in_val    (req_brightness),
      .out_valid (hue_valid),
      .out_ready (hue_ready),
      .out_data  (hue_data)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hue_valid),
      .in_ready  (hue_ready),
      .in_data   (hue_data),
      .out_valid (chan_valid),
      .out_ready (chan_ready),
      .out_data  (chan_data)
   );

   hsv2rgb_route u_route (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chan_valid),
      .in_ready  (chan_ready),
      .in_data   (chan_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

endmodule

>>> src/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// Port-level checks of the HSV to RGB converter, bound to the top level.
// ----------------------------------------------------------------------------
module hsv2rgb_checker
   import hsv2rgb_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_red,
   input logic [DATA_W-1:0] rsp_green,
   input logic [DATA_W-1:0] rsp_blue
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("result item changed while stalled");

   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red <= ONE_VAL && rsp_green <= ONE_VAL && rsp_blue <= ONE_VAL)
      else $error("result channel above 1.0");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalled with empty output stage");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_red   (rsp_red),
   .rsp_green (rsp_green),
   .rsp_blue  (rsp_blue)
);
